/* hw/rtl/lwfc_pkg.sv */
`default_nettype none

package lwfc_pkg;

  // screen geometry, rotation 0/2 portrait, 1/3 landscape
  localparam int unsigned SCREEN_SHORT_SIDE = 320;
  localparam int unsigned SCREEN_LONG_SIDE  = 480;
  localparam int unsigned DIM_W             = 11;

  // word kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_FILL = 2'd2;
  localparam logic [1:0] KIND_COPY = 2'd3;

  localparam logic REQ_FILL = 1'b0;
  localparam logic REQ_COPY = 1'b1;

  // controller opcodes
  localparam logic [7:0] OP_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] OP_ROW_SET      = 8'h2B;
  localparam logic [7:0] OP_MEMORY_WRITE = 8'h2C;

  // beat positions within one request
  localparam logic [3:0] BEAT_COL_CMD  = 4'd0;
  localparam logic [3:0] BEAT_COL_SH   = 4'd1;
  localparam logic [3:0] BEAT_COL_SL   = 4'd2;
  localparam logic [3:0] BEAT_COL_EH   = 4'd3;
  localparam logic [3:0] BEAT_COL_EL   = 4'd4;
  localparam logic [3:0] BEAT_ROW_CMD  = 4'd5;
  localparam logic [3:0] BEAT_ROW_SH   = 4'd6;
  localparam logic [3:0] BEAT_ROW_SL   = 4'd7;
  localparam logic [3:0] BEAT_ROW_EH   = 4'd8;
  localparam logic [3:0] BEAT_ROW_EL   = 4'd9;
  localparam logic [3:0] BEAT_MEM_CMD  = 4'd10;
  localparam logic [3:0] BEAT_BURST    = 4'd11;

  typedef struct packed {
    logic        req_type;
    logic [9:0]  x_start;
    logic [9:0]  y_start;
    logic [9:0]  rect_width;
    logic [9:0]  rect_height;
    logic [15:0] fill_pixel;
    logic [31:0] source_address;
  } req_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] x_start;
    logic [15:0] x_end;
    logic [15:0] y_start;
    logic [15:0] y_end;
    logic [15:0] fill_pixel;
    logic [31:0] source_address;
    logic [20:0] pixel_count;
  } job_t;

endpackage

`default_nettype wire

/* hw/rtl/lcd_window_fill_copy_sequencer.sv */
`default_nettype none

// Rectangle request to display command stream.
// Channels: request beats on in_valid/in_ready, one rotation write on
// cfg_valid/cfg_ready/cfg_data (always ready), output words on
// out_valid/out_ready.
// A surviving request yields twelve words: column-set command and four bytes,
// row-set command and four bytes, memory-write command, then one burst word
// with is_last set. Fills are clipped at the right and bottom edges; empty
// fills and copies that cross an edge give no words.
// A request passes the input register, the job register and the output word
// register in that order. Throughput: one word per cycle while out_ready is
// high, set by the single output word register; the next request is taken and
// its window worked out while the current one is still being serialised. A
// dropped request leaves the input register without waiting for the job stage.
// Reset: rotation returns to 0, all stages are emptied.
// Stall: a word held on out_valid stays unchanged until out_ready; the
// serialiser and then the input stage back up behind it.
module lcd_window_fill_copy_sequencer import lwfc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [9:0]  x_start,
  input  wire logic [9:0]  y_start,
  input  wire logic [9:0]  rect_width,
  input  wire logic [9:0]  rect_height,
  input  wire logic [15:0] fill_pixel,
  input  wire logic [31:0] source_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       word_kind,
  output logic [7:0]       byte_value,
  output logic [15:0]      burst_pixel,
  output logic [31:0]      burst_address,
  output logic [20:0]      pixel_count,
  output logic             is_last
);

  logic [1:0] rotation;
  logic       req_valid;
  req_t       req;
  logic       win_keep;
  job_t       win_job;
  logic       job_valid;
  job_t       job;
  logic [3:0] beat;
  logic       out_load, job_done, job_free, req_take;

  logic [1:0]  kind_next;
  logic [7:0]  byte_next;
  logic [15:0] pixel_next;
  logic [31:0] addr_next;
  logic [20:0] count_next;
  logic        last_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= 2'd0;
    end else if (cfg_valid) begin
      rotation <= cfg_data;
    end
  end

  lwfc_window u_window (
    .rotation (rotation),
    .req      (req),
    .keep     (win_keep),
    .job      (win_job)
  );

  assign out_load = job_valid && (!out_valid || out_ready);
  assign job_done = out_load && (beat == BEAT_BURST);
  assign job_free = !job_valid || job_done;
  assign req_take = req_valid && (!win_keep || job_free);
  assign in_ready = !req_valid || req_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req.req_type       <= req_type;
      req.x_start        <= x_start;
      req.y_start        <= y_start;
      req.rect_width     <= rect_width;
      req.rect_height    <= rect_height;
      req.fill_pixel     <= fill_pixel;
      req.source_address <= source_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      beat      <= BEAT_COL_CMD;
    end else if (req_take && win_keep) begin
      job_valid <= 1'b1;
      beat      <= BEAT_COL_CMD;
    end else begin
      if (out_load) begin
        beat <= beat + 4'd1;
      end
      if (job_done) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take && win_keep) begin
      job <= win_job;
    end
  end

  always_comb begin
    kind_next  = KIND_DATA;
    byte_next  = 8'd0;
    pixel_next = 16'd0;
    addr_next  = 32'd0;
    count_next = 21'd0;
    last_next  = 1'b0;
    unique case (beat)
      BEAT_COL_CMD: begin
        kind_next = KIND_CMD;
        byte_next = OP_COLUMN_SET;
      end
      BEAT_COL_SH: byte_next = job.x_start[15:8];
      BEAT_COL_SL: byte_next = job.x_start[7:0];
      BEAT_COL_EH: byte_next = job.x_end[15:8];
      BEAT_COL_EL: byte_next = job.x_end[7:0];
      BEAT_ROW_CMD: begin
        kind_next = KIND_CMD;
        byte_next = OP_ROW_SET;
      end
      BEAT_ROW_SH: byte_next = job.y_start[15:8];
      BEAT_ROW_SL: byte_next = job.y_start[7:0];
      BEAT_ROW_EH: byte_next = job.y_end[15:8];
      BEAT_ROW_EL: byte_next = job.y_end[7:0];
      BEAT_MEM_CMD: begin
        kind_next = KIND_CMD;
        byte_next = OP_MEMORY_WRITE;
      end
      BEAT_BURST: begin
        count_next = job.pixel_count;
        last_next  = 1'b1;
        if (job.req_type == REQ_FILL) begin
          kind_next  = KIND_FILL;
          pixel_next = job.fill_pixel;
        end else begin
          kind_next = KIND_COPY;
          addr_next = job.source_address;
        end
      end
      default: begin
        kind_next = KIND_CMD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      word_kind     <= kind_next;
      byte_value    <= byte_next;
      burst_pixel   <= pixel_next;
      burst_address <= addr_next;
      pixel_count   <= count_next;
      is_last       <= last_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lwfc_window.sv */
`default_nettype none

module lwfc_window import lwfc_pkg::*; (
  input  wire logic [1:0] rotation,
  input  wire req_t       req,
  output logic            keep,
  output job_t            job
);

  logic [DIM_W-1:0]  scr_w, scr_h;
  logic [DIM_W-1:0]  x_excl, y_excl, x_lim, y_lim, span_x, span_y;
  logic              x_ok, y_ok;
  logic [2*DIM_W-1:0] prod;

  always_comb begin
    scr_w = rotation[0] ? DIM_W'(SCREEN_LONG_SIDE) : DIM_W'(SCREEN_SHORT_SIDE);
    scr_h = rotation[0] ? DIM_W'(SCREEN_SHORT_SIDE) : DIM_W'(SCREEN_LONG_SIDE);

    x_excl = {1'b0, req.x_start} + {1'b0, req.rect_width};
    y_excl = {1'b0, req.y_start} + {1'b0, req.rect_height};

    // a copy that survives never exceeds the edge, so the clip leaves it alone
    x_lim = (x_excl > scr_w) ? scr_w : x_excl;
    y_lim = (y_excl > scr_h) ? scr_h : y_excl;

    if (req.req_type == REQ_FILL) begin
      x_ok = x_lim > {1'b0, req.x_start};
      y_ok = y_lim > {1'b0, req.y_start};
    end else begin
      x_ok = x_excl <= scr_w;
      y_ok = y_excl <= scr_h;
    end
    keep = x_ok && y_ok;

    span_x = x_lim - {1'b0, req.x_start};
    span_y = y_lim - {1'b0, req.y_start};
    prod   = span_x * span_y;

    job.req_type       = req.req_type;
    job.x_start        = {6'b0, req.x_start};
    job.y_start        = {6'b0, req.y_start};
    // zero-size copy wraps to start-1 modulo 2^16
    job.x_end          = {5'b0, x_lim} - 16'd1;
    job.y_end          = {5'b0, y_lim} - 16'd1;
    job.fill_pixel     = req.fill_pixel;
    job.source_address = req.source_address;
    job.pixel_count    = prod[20:0];
  end

endmodule

`default_nettype wire

/* hw/rtl/lwfc_checker.sv */
`default_nettype none

module lwfc_checker import lwfc_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  word_kind,
  input wire logic [7:0]  byte_value,
  input wire logic [15:0] burst_pixel,
  input wire logic [31:0] burst_address,
  input wire logic [20:0] pixel_count,
  input wire logic        is_last
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_kind) && $stable(byte_value)
      && $stable(burst_pixel) && $stable(burst_address) && $stable(pixel_count)
      && $stable(is_last))
    else $error("output beat changed while stalled");

  a_last_is_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_last == (word_kind == KIND_FILL || word_kind == KIND_COPY)))
    else $error("is_last does not match burst kind");

  a_byte_words_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (word_kind == KIND_CMD || word_kind == KIND_DATA)
      |-> pixel_count == 21'd0 && burst_pixel == 16'd0 && burst_address == 32'd0)
    else $error("burst fields set on a byte word");

  a_burst_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (word_kind == KIND_FILL || word_kind == KIND_COPY)
      |-> byte_value == 8'd0 && pixel_count <= 21'd1048576)
    else $error("bad burst word");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lcd_window_fill_copy_sequencer lwfc_checker u_lwfc_checker (.*);

`default_nettype wire
